/* sv/cedr_pkg.sv */
package cedr_pkg;

   localparam int unsigned CHANNEL_W   = 7;
   localparam int unsigned SAMPLE_W    = 10;
   localparam int unsigned DEADBAND_W  = 10;
   localparam int unsigned MUX_COUNT_W = 4;
   localparam int unsigned CSR_DATA_W  = 10;

   localparam int unsigned DEF_PINS_PER_MUX = 16;
   localparam int unsigned DEF_MAX_MUX      = 8;
   localparam int unsigned DEF_SAMPLE_BITS  = 10;

   localparam logic [DEADBAND_W-1:0]  DEADBAND_RESET  = DEADBAND_W'(4);
   localparam logic [MUX_COUNT_W-1:0] MUX_COUNT_RESET = MUX_COUNT_W'(1);

   typedef enum logic [0:0] {
      CSR_DEADBAND  = 1'b0,
      CSR_MUX_COUNT = 1'b1
   } csr_index_type;

endpackage

/* sv/cedr_req_if.sv */
interface cedr_req_if;
   import cedr_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHANNEL_W-1:0] channel;
   logic [SAMPLE_W-1:0]  sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink   (input valid, input channel, input sample, output ready);
endinterface

/* sv/cedr_rsp_if.sv */
interface cedr_rsp_if;
   import cedr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] report_channel;
   logic [SAMPLE_W-1:0]  report_value;

   modport source (output valid, output report_channel, output report_value, input ready);
   modport sink   (input valid, input report_channel, input report_value, output ready);
endinterface

/* sv/channel_ema_deadband_reporter_top.sv */
// Per-channel moving-average filter with a report deadband.
// Each word on req_bus carries a channel number and a converter sample. The
// channel's filtered value becomes floor((filtered + 4 * sample) / 5), and when
// it has moved more than the deadband away from the value last reported for
// that channel, a word with the channel and the new value leaves on rsp_bus.
// Channels at or above PINS_PER_MUX times the mux count (capped at MAX_MUX) are taken and dropped.
// The csr port sets the deadband (index 0) and the mux count (index 1); write
// it only while no word is in flight.
// One word is taken every cycle unless a stalled report holds the update stage.
// A report reaches rsp_bus after the synchronous read of the channel store,
// then the update and write-back into the output register.
// Back-to-back words on the same channel are served by forwarding the value
// being written. When the receiver stalls with a report pending, the update
// stage holds a reporting word and req_bus.ready drops until the report is taken.
// Reset is synchronous; it clears one valid bit per store entry, so every
// channel reads as zero again at once, with no clearing pass.
module channel_ema_deadband_reporter_top #(
   parameter int unsigned PINS_PER_MUX = cedr_pkg::DEF_PINS_PER_MUX,
   parameter int unsigned MAX_MUX      = cedr_pkg::DEF_MAX_MUX,
   parameter int unsigned SAMPLE_BITS  = cedr_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   cedr_req_if.sink                               req_bus,
   cedr_rsp_if.source                             rsp_bus,
   input  logic                                   csr_write_en,
   input  cedr_pkg::csr_index_type                csr_index,
   input  logic [cedr_pkg::CSR_DATA_W-1:0]        csr_data
);
   import cedr_pkg::*;

   localparam int unsigned STORE_DEPTH = PINS_PER_MUX * MAX_MUX;
   localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
   localparam int unsigned LIMIT_W     = $clog2(STORE_DEPTH + 1);
   localparam int unsigned MUX_CMP_W   = MUX_COUNT_W + 2;
   localparam int unsigned SUM_W       = SAMPLE_BITS + 3;
   localparam int unsigned SHIFT       = SUM_W + 2;
   localparam int unsigned PROD_W      = SUM_W + SHIFT;
   localparam longint unsigned RECIP5  = ((longint'(1) << SHIFT) + 4) / 5;
   localparam int unsigned CMP_W       = (SAMPLE_BITS > DEADBAND_W) ? SAMPLE_BITS : DEADBAND_W;
   localparam int unsigned ENTRY_W     = 2 * SAMPLE_BITS;

   logic [DEADBAND_W-1:0]  deadband_ff, deadband_in;
   logic [MUX_COUNT_W-1:0] mux_count_ff, mux_count_in;

   logic [ENTRY_W-1:0]     mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] valid_ff;
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   rd_valid_ff;
   logic                   fwd_hit_ff;
   logic [ENTRY_W-1:0]     fwd_data_ff;

   logic                   s1_valid_ff, s1_valid_in;
   logic [CHANNEL_W-1:0]   s1_channel_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_W-1:0]   rsp_channel_ff;
   logic [SAMPLE_W-1:0]    rsp_value_ff;

   logic [MUX_COUNT_W-1:0] muxes;
   logic [LIMIT_W-1:0]     limit;
   logic                   in_use;
   logic                   accept;
   logic [ADDR_W-1:0]      req_addr;
   logic [ADDR_W-1:0]      s1_addr;
   logic [ENTRY_W-1:0]     old_entry;
   logic [SAMPLE_BITS-1:0] filt_old;
   logic [SAMPLE_BITS-1:0] sent_old;
   logic [SUM_W-1:0]       sum;
   logic [PROD_W-1:0]      prod;
   logic [SAMPLE_BITS-1:0] filt_new;
   logic [SAMPLE_BITS-1:0] diff;
   logic                   report;
   logic [SAMPLE_BITS-1:0] sent_new;
   logic [ENTRY_W-1:0]     wr_data;
   logic                   s1_go;
   logic                   s1_wr;

   // Configuration registers.
   always_comb begin
      deadband_in  = deadband_ff;
      mux_count_in = mux_count_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEADBAND:  deadband_in  = DEADBAND_W'(csr_data);
            CSR_MUX_COUNT: mux_count_in = MUX_COUNT_W'(csr_data);
            default:       deadband_in  = deadband_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= DEADBAND_RESET;
         mux_count_ff <= MUX_COUNT_RESET;
      end else begin
         deadband_ff  <= deadband_in;
         mux_count_ff <= mux_count_in;
      end
   end

   // Request stage: range check and store read.
   always_comb begin
      if (MUX_CMP_W'(mux_count_ff) > MUX_CMP_W'(MAX_MUX)) begin
         muxes = MUX_COUNT_W'(MAX_MUX);
      end else begin
         muxes = mux_count_ff;
      end
   end

   assign limit    = LIMIT_W'(PINS_PER_MUX * muxes);
   assign in_use   = (LIMIT_W + CHANNEL_W)'(req_bus.channel) < (LIMIT_W + CHANNEL_W)'(limit);
   assign req_addr = ADDR_W'(req_bus.channel);
   assign accept   = req_bus.valid && req_bus.ready;

   // Update stage.
   assign s1_addr   = ADDR_W'(s1_channel_ff);
   assign old_entry = fwd_hit_ff ? fwd_data_ff : (rd_valid_ff ? rd_data_ff : '0);
   assign filt_old  = old_entry[ENTRY_W-1:SAMPLE_BITS];
   assign sent_old  = old_entry[SAMPLE_BITS-1:0];
   assign sum       = SUM_W'(filt_old) + (SUM_W'(s1_sample_ff) << 2);
   assign prod      = PROD_W'(sum) * PROD_W'(RECIP5);
   assign filt_new  = SAMPLE_BITS'(prod >> SHIFT);
   assign diff      = (filt_new >= sent_old) ? (filt_new - sent_old) : (sent_old - filt_new);
   assign report    = CMP_W'(diff) > CMP_W'(deadband_ff);
   assign sent_new  = report ? filt_new : sent_old;
   assign wr_data   = {filt_new, sent_new};

   assign s1_go         = !(report && rsp_valid_ff && !rsp_bus.ready);
   assign s1_wr         = s1_valid_ff && s1_go;
   assign req_bus.ready = !s1_valid_ff || s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_bus.ready) begin
         s1_valid_in = accept && in_use;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_wr && report) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_wr) begin
         mem[s1_addr] <= wr_data;
      end
      if (accept) begin
         rd_data_ff <= mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_wr) begin
            valid_ff[s1_addr] <= 1'b1;
         end
         if (accept) begin
            rd_valid_ff <= valid_ff[req_addr];
            fwd_hit_ff  <= s1_wr && (s1_addr == req_addr);
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_channel_ff <= req_bus.channel;
         s1_sample_ff  <= SAMPLE_BITS'(req_bus.sample);
         fwd_data_ff   <= wr_data;
      end
      if (s1_wr && report) begin
         rsp_channel_ff <= s1_channel_ff;
         rsp_value_ff   <= SAMPLE_W'(filt_new);
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.report_channel = rsp_channel_ff;
   assign rsp_bus.report_value   = rsp_value_ff;

   a_report_loads_output: assert property (@(posedge clock) disable iff (reset)
      s1_wr && report |=> rsp_valid_ff)
      else $error("A report from the update stage did not reach the output register.");

   a_unused_channel_dropped: assert property (@(posedge clock) disable iff (reset)
      accept && !in_use |=> !s1_valid_ff)
      else $error("A word for a channel not in use entered the update stage.");

   a_forward_needs_write: assert property (@(posedge clock) disable iff (reset)
      $rose(fwd_hit_ff) |-> $past(s1_wr))
      else $error("Forwarding was flagged without a store write in the same cycle.");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      s1_wr |=> valid_ff[$past(s1_addr)])
      else $error("A store write did not mark its entry valid.");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_channel_ff))
      else $error("The update stage dropped its word while the output was stalled.");

endmodule

/* bench/channel_ema_deadband_reporter_top_tb.sv */
`timescale 1ns / 1ps

module channel_ema_deadband_reporter_top_tb;
   import cedr_pkg::*;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
   } sample_word_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  value;
   } report_word_type;

   localparam int unsigned CHANNEL_SLOTS = DEF_PINS_PER_MUX * DEF_MAX_MUX;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   cedr_req_if req_if();
   cedr_rsp_if rsp_if();

   channel_ema_deadband_reporter_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_if),
      .rsp_bus      (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   sample_word_type sample_queue[$];
   report_word_type report_queue[$];

   logic [SAMPLE_W-1:0]    filtered_level [CHANNEL_SLOTS];
   logic [SAMPLE_W-1:0]    reported_level [CHANNEL_SLOTS];
   logic [DEADBAND_W-1:0]  deadband_reg;
   logic [MUX_COUNT_W-1:0] mux_count_reg;

   int unsigned pushed_count;
   int unsigned accepted_count;
   int unsigned mismatch_count;
   int unsigned req_gap_max;
   int unsigned rsp_stall_max;
   int unsigned req_gap;
   int unsigned rsp_wait;
   logic        req_taken;
   logic        rsp_taken;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Updates the channel's moving average and queues a report when the new
   // level has moved beyond the deadband from the last reported level.
   function automatic void filter_sample(input logic [CHANNEL_W-1:0] ch,
                                         input logic [SAMPLE_W-1:0] s);
      int unsigned muxes;
      int unsigned span;
      int unsigned level;
      int unsigned drift;
      report_word_type rep;
      muxes = (mux_count_reg > DEF_MAX_MUX) ? DEF_MAX_MUX : mux_count_reg;
      span = DEF_PINS_PER_MUX * muxes;
      if (ch >= span) begin
         return;
      end
      level = (int'(filtered_level[ch]) + 4 * int'(s)) / 5;
      filtered_level[ch] = level[SAMPLE_W-1:0];
      drift = (level >= reported_level[ch]) ? level - reported_level[ch]
                                            : reported_level[ch] - level;
      if (drift > deadband_reg) begin
         reported_level[ch] = level[SAMPLE_W-1:0];
         rep.channel = ch;
         rep.value = level[SAMPLE_W-1:0];
         report_queue.push_back(rep);
      end
   endfunction

   always @(posedge clock) begin
      report_word_type want;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            accepted_count++;
            filter_sample(req_if.channel, req_if.sample);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_taken = 1'b1;
            if (report_queue.size() == 0) begin
               flag_mismatch($sformatf("unexpected report channel %0d value %0d",
                                       rsp_if.report_channel, rsp_if.report_value));
            end else begin
               want = report_queue.pop_front();
               if (rsp_if.report_channel !== want.channel) begin
                  flag_mismatch($sformatf("report_channel %0d, expected %0d",
                                          rsp_if.report_channel, want.channel));
               end
               if (rsp_if.report_value !== want.value) begin
                  flag_mismatch($sformatf("report_value %0d, expected %0d (channel %0d)",
                                          rsp_if.report_value, want.value, want.channel));
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      sample_word_type word;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else if (!req_if.valid || req_taken) begin
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap = req_gap - 1;
         end else if (sample_queue.size() != 0) begin
            word = sample_queue.pop_front();
            req_if.valid <= 1'b1;
            req_if.channel <= word.channel;
            req_if.sample <= word.sample;
            req_gap = $urandom_range(0, req_gap_max);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_taken) begin
            rsp_wait = $urandom_range(0, rsp_stall_max);
         end
         if (rsp_wait > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_wait = rsp_wait - 1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic queue_sample(input int unsigned ch, input int unsigned s);
      sample_word_type word;
      word.channel = ch[CHANNEL_W-1:0];
      word.sample = s[SAMPLE_W-1:0];
      sample_queue.push_back(word);
      pushed_count++;
   endtask

   // Words that give no report may still be in the pipeline, so the task keeps
   // waiting after the last report before the block counts as idle.
   task automatic wait_for_quiet();
      while (accepted_count != pushed_count || report_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (6) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      if (idx == CSR_DEADBAND) begin
         deadband_reg = data[DEADBAND_W-1:0];
      end else begin
         mux_count_reg = data[MUX_COUNT_W-1:0];
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic reconfigure(input int unsigned band, input int unsigned mux_data);
      wait_for_quiet();
      write_csr(CSR_DEADBAND, band[CSR_DATA_W-1:0]);
      write_csr(CSR_MUX_COUNT, mux_data[CSR_DATA_W-1:0]);
   endtask

   initial begin
      int unsigned phase;
      int unsigned band;
      int unsigned muxes;
      int unsigned span;
      int unsigned live;
      int unsigned ch;
      int          s;

      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_DEADBAND;
      csr_data = '0;
      req_if.valid = 1'b0;
      req_if.channel = '0;
      req_if.sample = '0;
      rsp_if.ready = 1'b0;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      pushed_count = 0;
      accepted_count = 0;
      mismatch_count = 0;
      req_gap_max = 9;
      rsp_stall_max = 9;
      deadband_reg = DEADBAND_RESET;
      mux_count_reg = MUX_COUNT_RESET;
      foreach (filtered_level[i]) begin
         filtered_level[i] = '0;
         reported_level[i] = '0;
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: deadband of four, one mux.
      queue_sample(0, 1023);
      queue_sample(0, 1023);
      queue_sample(15, 0);
      queue_sample(16, 1023);
      queue_sample(127, 1023);
      queue_sample(1, 5);
      queue_sample(1, 7);
      queue_sample(0, 0);

      reconfigure(0, 8);
      queue_sample(127, 1023);
      queue_sample(127, 1023);
      queue_sample(64, 1);
      queue_sample(64, 2);
      queue_sample(64, 2);

      // A mux count above the maximum saturates; upper data bits are ignored.
      reconfigure(1023, 10'h3FF);
      queue_sample(127, 0);
      queue_sample(100, 1023);

      // With no mux in use every word is dropped.
      reconfigure(0, 0);
      queue_sample(0, 1023);
      queue_sample(5, 512);
      queue_sample(127, 1023);

      reconfigure(4, 1);
      queue_sample(0, 1023);
      queue_sample(15, 1023);

      for (phase = 0; phase < 8; phase++) begin
         if (phase == 0) begin
            band = 0;
            muxes = 8;
         end else if (phase == 1) begin
            band = 1;
            muxes = 1;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: band = $urandom_range(0, 15);
               5, 6, 7, 8:    band = $urandom_range(16, 127);
               default:       band = $urandom_range(128, 1023);
            endcase
            muxes = $urandom_range(1, 15);
         end
         reconfigure(band, ($urandom_range(0, 63) << MUX_COUNT_W) | muxes);
         req_gap_max = (phase % 3 == 1) ? 0 : 9;
         rsp_stall_max = (phase % 3 == 1) ? 0 : 9;
         span = DEF_PINS_PER_MUX * ((muxes > DEF_MAX_MUX) ? DEF_MAX_MUX : muxes);
         live = 0;
         while (live < 165) begin
            if ($urandom_range(0, 99) < 85) begin
               ch = $urandom_range(0, span - 1);
            end else begin
               ch = $urandom_range(0, CHANNEL_SLOTS - 1);
            end
            if (ch < span) begin
               live++;
            end
            if ($urandom_range(0, 1) == 0) begin
               s = $urandom_range(0, 1023);
            end else begin
               s = int'(filtered_level[ch]) + int'($urandom_range(0, 80)) - 40;
               s = (s < 0) ? 0 : ((s > 1023) ? 1023 : s);
            end
            queue_sample(ch, s);
            if (phase == 2 && live == 80) begin
               wait_for_quiet();
            end
         end
      end

      wait_for_quiet();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
